// ----- design/ipm_pkg.sv -----
package ipm_pkg;

	localparam int OUT_HEIGHT = 400;
	localparam int OUT_WIDTH  = 400;
	localparam int SRC_HEIGHT = 360;
	localparam int SRC_WIDTH  = 720;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FORWARD_OFFSET  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LATERAL_OFFSET  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_HEIGHT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_BASE_ANGLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HORZ_BASE_ANGLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_SCALE      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HORZ_SCALE      = 3'd6;

	localparam logic [15:0] CAMERA_HEIGHT_RST = 16'd461;

	// Reciprocals for exact truncating division of values below 4096.
	localparam logic [12:0] RECIP_10 = 13'd6554;
	localparam logic [13:0] RECIP_5  = 14'd13108;

	localparam int SQ_STEPS = 19;
	localparam int SQ_W = 38;
	localparam int CORDIC_STEPS = 16;
	localparam int CH_W = 29;
	localparam int CV_W = 42;
	localparam int Z_W = 19;

	localparam logic signed [Z_W-1:0] HALF_PI_Q16 = 19'sd102944;
	localparam logic signed [13:0] HALF_PI_Q12 = 14'sd6434;

	localparam logic [16:0] ATAN_TAB [CORDIC_STEPS] = '{
		17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
		17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2
	};

	typedef struct packed {
		logic [8:0] afwd;
		logic [9:0] alat;
		logic       fneg;
		logic       lneg;
		logic       fzero;
		logic       lzero;
	} side_t;

endpackage

// ----- design/inverse_perspective_remap_address_unit.sv -----
// Remap address generator for a ground-plane view: each transaction on the slave side carries
// one output pixel (row, column) and produces exactly one transaction on the master side with
// the camera-image row and column that feed it, plus a flag that is low when the pixel falls
// outside the source frame or straight ahead of the camera. The unit is a 45-stage pipeline:
// a new pixel is taken every cycle while the master side does not stall, and each result is
// offered from the output register once it has passed every stage. The depth is set by the 19
// stages of the square root and the 16 stages of the two CORDIC units.
// A stall on the master side holds the whole pipeline. The user must write registers through the
// configuration port only while no pixel is in flight; the block itself does not enforce this.
module inverse_perspective_remap_address_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [ipm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ipm_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // out_row[8:0], out_col[17:9], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // src_row[8:0], src_col[18:9], zero fill
	output logic        m_tuser   // valid_res
);
	import ipm_pkg::*;

	localparam int NST = 5 + SQ_STEPS + 1 + CORDIC_STEPS + 4;

	logic signed [10:0] fo_q, lo_q;
	logic [15:0] height_q;
	logic signed [15:0] vba_q, hba_q;
	logic [15:0] vscale_q, hscale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fo_q <= '0;
			lo_q <= '0;
			height_q <= CAMERA_HEIGHT_RST;
			vba_q <= '0;
			hba_q <= '0;
			vscale_q <= '0;
			hscale_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FORWARD_OFFSET:  fo_q <= cfg_wdata[10:0];
				REG_LATERAL_OFFSET:  lo_q <= cfg_wdata[10:0];
				REG_CAMERA_HEIGHT:   height_q <= cfg_wdata;
				REG_VERT_BASE_ANGLE: vba_q <= cfg_wdata;
				REG_HORZ_BASE_ANGLE: hba_q <= cfg_wdata;
				REG_VERT_SCALE:      vscale_q <= cfg_wdata;
				REG_HORZ_SCALE:      hscale_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic en;
	logic [NST-1:0] vld_q;

	assign en = !vld_q[NST-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], s_tvalid};
		end
	end

	// Stage 1: distances before scaling.
	logic signed [13:0] nf_c, nl_c;
	logic [11:0] anf_s1, anl_s1;
	logic fs_s1, ls_s1;

	always_comb begin
		nf_c = 14'(OUT_HEIGHT) - $signed({5'b0, s_tdata[8:0]}) - 14'(fo_q);
		nl_c = $signed({5'b0, s_tdata[17:9]}) - 14'(OUT_WIDTH / 2) - 14'(lo_q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			anf_s1 <= 12'(nf_c[13] ? -nf_c : nf_c);
			anl_s1 <= 12'(nl_c[13] ? -nl_c : nl_c);
			fs_s1 <= nf_c[13];
			ls_s1 <= nl_c[13];
		end
	end

	// Stage 2: multiply by reciprocals.
	logic [24:0] pf_s2;
	logic [25:0] pl_s2;
	logic fs_s2, ls_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			pf_s2 <= anf_s1 * RECIP_10;
			pl_s2 <= anl_s1 * RECIP_5;
			fs_s2 <= fs_s1;
			ls_s2 <= ls_s1;
		end
	end

	// Stage 3: truncated quotients and their signs.
	side_t sb_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s3.afwd <= pf_s2[24:16];
			sb_s3.alat <= pl_s2[25:16];
			sb_s3.fzero <= pf_s2[24:16] == '0;
			sb_s3.lzero <= pl_s2[25:16] == '0;
			sb_s3.fneg <= fs_s2 && pf_s2[24:16] != '0;
			sb_s3.lneg <= ls_s2 && pl_s2[25:16] != '0;
		end
	end

	// Stage 4 and 5: squared distance, scaled for the root.
	logic [17:0] sqf_s4;
	logic [19:0] sql_s4;
	side_t sb_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sqf_s4 <= sb_s3.afwd * sb_s3.afwd;
			sql_s4 <= sb_s3.alat * sb_s3.alat;
			sb_s4 <= sb_s3;
		end
	end

	logic [SQ_W-1:0] sq_rem_s [SQ_STEPS+1];
	logic [SQ_W-1:0] sq_res_s [SQ_STEPS+1];
	side_t sq_sb_s [SQ_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rem_s[0] <= {SQ_W'({1'b0, sqf_s4} + {1'b0, sql_s4}) << 16};
			sq_res_s[0] <= '0;
			sq_sb_s[0] <= sb_s4;
		end
	end

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (SQ_STEPS - 1 - j));
		logic [SQ_W-1:0] trial;
		assign trial = sq_res_s[j] + BITV;
		always_ff @(posedge clk) begin
			if (en) begin
				sq_sb_s[j+1] <= sq_sb_s[j];
				if (sq_rem_s[j] >= trial) begin
					sq_rem_s[j+1] <= sq_rem_s[j] - trial;
					sq_res_s[j+1] <= (sq_res_s[j] >> 1) + BITV;
				end else begin
					sq_rem_s[j+1] <= sq_rem_s[j];
					sq_res_s[j+1] <= sq_res_s[j] >> 1;
				end
			end
		end
	end

	// CORDIC units, horizontal and vertical side by side.
	logic signed [CH_W-1:0] hx_s [CORDIC_STEPS+1];
	logic signed [CH_W-1:0] hy_s [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]  hz_s [CORDIC_STEPS+1];
	logic signed [CV_W-1:0] vx_s [CORDIC_STEPS+1];
	logic signed [CV_W-1:0] vy_s [CORDIC_STEPS+1];
	logic signed [Z_W-1:0]  vz_s [CORDIC_STEPS+1];
	side_t cr_sb_s [CORDIC_STEPS+1];

	always_ff @(posedge clk) begin
		if (en) begin
			hx_s[0] <= CH_W'({sq_sb_s[SQ_STEPS].afwd, 16'b0});
			hy_s[0] <= CH_W'({sq_sb_s[SQ_STEPS].alat, 16'b0});
			hz_s[0] <= '0;
			vx_s[0] <= CV_W'({sq_res_s[SQ_STEPS][18:0], 20'b0});
			vy_s[0] <= CV_W'({height_q, 20'b0});
			vz_s[0] <= '0;
			cr_sb_s[0] <= sq_sb_s[SQ_STEPS];
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
		localparam logic signed [Z_W-1:0] ANG = Z_W'(ATAN_TAB[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				cr_sb_s[i+1] <= cr_sb_s[i];
				if (hy_s[i] > 0) begin
					hx_s[i+1] <= hx_s[i] + (hy_s[i] >>> i);
					hy_s[i+1] <= hy_s[i] - (hx_s[i] >>> i);
					hz_s[i+1] <= hz_s[i] + ANG;
				end else begin
					hx_s[i+1] <= hx_s[i] - (hy_s[i] >>> i);
					hy_s[i+1] <= hy_s[i] + (hx_s[i] >>> i);
					hz_s[i+1] <= hz_s[i] - ANG;
				end
				if (vy_s[i] > 0) begin
					vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] + ANG;
				end else begin
					vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] - ANG;
				end
			end
		end
	end

	// Final angle stage: clamp, round to signed Q1.12, apply quadrant.
	logic signed [Z_W-1:0] hzc_c, vzc_c;
	logic signed [13:0] hq_c, vq_c, ah_c, av_c;
	side_t f_sb;
	logic signed [13:0] ah_sf, av_sf;
	logic lzero_sf;

	assign f_sb = cr_sb_s[CORDIC_STEPS];

	always_comb begin
		hzc_c = hz_s[CORDIC_STEPS];
		if (hzc_c < 0) hzc_c = '0;
		if (hzc_c > HALF_PI_Q16) hzc_c = HALF_PI_Q16;
		vzc_c = vz_s[CORDIC_STEPS];
		if (vzc_c < 0) vzc_c = '0;
		if (vzc_c > HALF_PI_Q16) vzc_c = HALF_PI_Q16;
		hq_c = 14'((hzc_c + 19'sd8) >>> 4);
		vq_c = 14'((vzc_c + 19'sd8) >>> 4);
		if (f_sb.fzero) begin
			ah_c = f_sb.lneg ? -HALF_PI_Q12 : HALF_PI_Q12;
		end else begin
			ah_c = (f_sb.fneg != f_sb.lneg) ? -hq_c : hq_c;
		end
		if (height_q == '0) begin
			av_c = '0;
		end else begin
			av_c = f_sb.fneg ? -vq_c : vq_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ah_sf <= ah_c;
			av_sf <= av_c;
			lzero_sf <= f_sb.lzero;
		end
	end

	// Subtract base angles, then scale.
	logic signed [16:0] dh_sd, dv_sd;
	logic lzero_sd;
	logic signed [33:0] ph_sm, pv_sm;
	logic lzero_sm;

	always_ff @(posedge clk) begin
		if (en) begin
			dh_sd <= 17'(ah_sf) - 17'(hba_q);
			dv_sd <= 17'(av_sf) - 17'(vba_q);
			lzero_sd <= lzero_sf;
			ph_sm <= dh_sd * $signed({1'b0, hscale_q});
			pv_sm <= dv_sd * $signed({1'b0, vscale_q});
			lzero_sm <= lzero_sd;
		end
	end

	// Output stage: truncate toward zero and check the frame.
	logic signed [33:0] rh_c, rv_c;
	logic signed [15:0] qc_c, qr_c;
	logic ok_c;
	logic [8:0] src_row_so;
	logic [9:0] src_col_so;
	logic valid_res_so;

	always_comb begin
		rh_c = ph_sm + (ph_sm[33] ? 34'sd262143 : 34'sd0);
		rv_c = pv_sm + (pv_sm[33] ? 34'sd262143 : 34'sd0);
		qc_c = rh_c[33:18];
		qr_c = rv_c[33:18];
		ok_c = !lzero_sm && !qr_c[15] && qr_c < 16'(SRC_HEIGHT) && !qc_c[15] &&
			qc_c < 16'(SRC_WIDTH);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			valid_res_so <= ok_c;
			src_row_so <= ok_c ? qr_c[8:0] : '0;
			src_col_so <= ok_c ? qc_c[9:0] : '0;
		end
	end

	assign m_tdata = {5'b0, src_col_so, src_row_so};
	assign m_tuser = valid_res_so;

	a_row_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> src_row_so < 9'(SRC_HEIGHT))
		else $error("source row outside frame");
	a_col_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> src_col_so < 10'(SRC_WIDTH))
		else $error("source column outside frame");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("invalid result carries nonzero address");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(vld_q))
		else $error("pipeline moved during stall");

endmodule

// ----- sim/tb_inverse_perspective_remap_address_unit.sv -----
`timescale 1ns / 100ps

module tb_inverse_perspective_remap_address_unit;
	import ipm_pkg::*;

	localparam int PIPE_LAT = 44;

	typedef struct packed {
		logic [8:0] row;
		logic [9:0] col;
		logic       ok;
	} src_addr_t;

	typedef struct {
		logic [8:0] out_row;
		logic [8:0] out_col;
		logic       typed;
		src_addr_t  addr;
	} pixel_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [23:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic m_tuser;

	logic signed [10:0] fwd_off_r, lat_off_r;
	logic [15:0] cam_h_r, vscale_r, hscale_r;
	logic signed [15:0] vbase_r, hbase_r;

	src_addr_t pending_addrs[$];
	int fail_cnt = 0;
	bit sink_quiet = 1'b0;
	bit hold_sink = 1'b0;
	bit hold_go = 1'b0;
	bit src_gaps = 1'b1;

	inverse_perspective_remap_address_unit dut (.*);

	always #6 clk = ~clk;

	initial begin
		#50ms;
		$display("inverse_perspective_remap_address_unit regression: fail");
		$finish;
	end

	function automatic longint floor_sr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint cordic_atan(longint x, longint y);
		longint z, nx, ny;
		longint tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		z = 0;
		if (y == 0)
			return 0;
		if (x == 0) begin
			z = 102944;
		end else begin
			for (int i = 0; i < 16; i++) begin
				if (y > 0) begin
					nx = x + floor_sr(y, i);
					ny = y - floor_sr(x, i);
					z += tab[i];
				end else begin
					nx = x - floor_sr(y, i);
					ny = y + floor_sr(x, i);
					z -= tab[i];
				end
				x = nx;
				y = ny;
			end
			if (z < 0)
				z = 0;
			if (z > 102944)
				z = 102944;
		end
		return (z + 8) >>> 4;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic src_addr_t remap_address(logic [8:0] orow, logic [8:0] ocol);
		longint fwd, lat, afwd, alat, ah, av, r, sr, sc;
		src_addr_t a;
		a = '0;
		fwd = (longint'(OUT_HEIGHT) - longint'(orow) - longint'(fwd_off_r)) / 10;
		lat = (longint'(ocol) - longint'(OUT_WIDTH / 2) - longint'(lat_off_r)) / 5;
		if (lat == 0)
			return a;
		afwd = fwd < 0 ? -fwd : fwd;
		alat = lat < 0 ? -lat : lat;
		if (fwd == 0) begin
			ah = lat < 0 ? -6434 : 6434;
		end else begin
			ah = cordic_atan(afwd <<< 16, alat <<< 16);
			if ((lat < 0) != (fwd < 0))
				ah = -ah;
		end
		r = int_sqrt(longint'(afwd * afwd + alat * alat) << 16);
		av = cordic_atan(r <<< 20, longint'(cam_h_r) <<< 20);
		if (fwd < 0)
			av = -av;
		sc = (ah - longint'(hbase_r)) * longint'(hscale_r) / 262144;
		sr = (av - longint'(vbase_r)) * longint'(vscale_r) / 262144;
		if (sr >= 0 && sr < SRC_HEIGHT && sc >= 0 && sc < SRC_WIDTH) begin
			a.row = sr[8:0];
			a.col = sc[9:0];
			a.ok = 1'b1;
		end
		return a;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FORWARD_OFFSET: fwd_off_r = val[10:0];
			REG_LATERAL_OFFSET: lat_off_r = val[10:0];
			REG_CAMERA_HEIGHT: cam_h_r = val;
			REG_VERT_BASE_ANGLE: vbase_r = val;
			REG_HORZ_BASE_ANGLE: hbase_r = val;
			REG_VERT_SCALE: vscale_r = val;
			REG_HORZ_SCALE: hscale_r = val;
			default: ;
		endcase
	endtask

	task automatic drain_results();
		while (pending_addrs.size() != 0)
			@(negedge clk);
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_pixel(logic [8:0] orow, logic [8:0] ocol, bit typed, src_addr_t want);
		src_addr_t a;
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		a = remap_address(orow, ocol);
		if (typed && a != want) begin
			$error("typed row %0d,%0d: predictor %h, table %h", orow, ocol, a, want);
			fail_cnt++;
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, ocol, orow};
		do @(posedge clk); while (!s_tready);
		pending_addrs.push_back(a);
		@(negedge clk);
	endtask

	task automatic idle_source();
		s_tvalid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (hold_sink)
			m_tready <= 1'b0;
		else if (!sink_quiet && $urandom_range(0, 5) == 0)
			m_tready <= 1'b0;
		else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		src_addr_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_addrs.size() == 0) begin
				$error("result with nothing expected: %h", m_tdata);
				fail_cnt++;
			end else begin
				want = pending_addrs.pop_front();
				if (m_tdata[8:0] !== want.row) begin
					$error("src_row expected %0d actual %0d", want.row, m_tdata[8:0]);
					fail_cnt++;
				end
				if (m_tdata[18:9] !== want.col) begin
					$error("src_col expected %0d actual %0d", want.col, m_tdata[18:9]);
					fail_cnt++;
				end
				if (m_tuser !== want.ok) begin
					$error("valid_res expected %0d actual %0d", want.ok, m_tuser);
					fail_cnt++;
				end
			end
		end
	end

	// Sink hold-off while the source keeps offering pixels.
	initial begin
		wait (hold_go);
		repeat (20) @(negedge clk);
		hold_sink = 1'b1;
		repeat (150) @(negedge clk);
		hold_sink = 1'b0;
	end

	task automatic random_phase(int n);
		logic [8:0] r, c;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: begin r = $urandom_range(0, 511); c = $urandom_range(0, 511); end
				1: begin r = $urandom_range(0, 399); c = 9'(200 + lat_off_r + $urandom_range(0, 8) - 4); end
				2: begin r = 9'(400 - fwd_off_r + $urandom_range(0, 18) - 9); c = $urandom_range(0, 399); end
				default: begin r = $urandom_range(0, 399); c = $urandom_range(0, 399); end
			endcase
			send_pixel(r, c, 1'b0, '0);
		end
		idle_source();
	endtask

	pixel_row_t pixel_table[$];

	initial begin
		fwd_off_r = 0;
		lat_off_r = 0;
		cam_h_r = CAMERA_HEIGHT_RST;
		vbase_r = 0;
		hbase_r = 0;
		vscale_r = 0;
		hscale_r = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset scales are zero, so every pixel off the center column maps to row 0, column 0.
		pixel_table = '{
			'{9'd0, 9'd0, 1'b1, '{9'd0, 10'd0, 1'b1}},
			'{9'd399, 9'd399, 1'b1, '{9'd0, 10'd0, 1'b1}},
			'{9'd0, 9'd200, 1'b1, '{9'd0, 10'd0, 1'b0}},
			'{9'd100, 9'd204, 1'b1, '{9'd0, 10'd0, 1'b0}},
			'{9'd511, 9'd511, 1'b1, '{9'd0, 10'd0, 1'b1}},
			'{9'd400, 9'd300, 1'b1, '{9'd0, 10'd0, 1'b1}},
			'{9'd395, 9'd100, 1'b1, '{9'd0, 10'd0, 1'b1}}
		};
		foreach (pixel_table[i])
			send_pixel(pixel_table[i].out_row, pixel_table[i].out_col, pixel_table[i].typed,
				pixel_table[i].addr);
		idle_source();
		drain_results();

		write_reg(REG_VERT_SCALE, 16'd6000);
		write_reg(REG_HORZ_SCALE, 16'd20000);
		write_reg(REG_VERT_BASE_ANGLE, -16'sd2000);
		write_reg(REG_HORZ_BASE_ANGLE, -16'sd6434);
		pixel_table = '{
			'{9'd0, 9'd0, 1'b0, '0}, '{9'd399, 9'd399, 1'b0, '0},
			'{9'd0, 9'd399, 1'b0, '0}, '{9'd399, 9'd0, 1'b0, '0},
			'{9'd395, 9'd300, 1'b0, '0}, '{9'd395, 9'd50, 1'b0, '0},
			'{9'd450, 9'd300, 1'b0, '0}, '{9'd511, 9'd100, 1'b0, '0},
			'{9'd200, 9'd207, 1'b0, '0}, '{9'd200, 9'd193, 1'b0, '0},
			'{9'd200, 9'd200, 1'b0, '0}, '{9'd256, 9'd256, 1'b0, '0}
		};
		foreach (pixel_table[i])
			send_pixel(pixel_table[i].out_row, pixel_table[i].out_col, 1'b0, '0);
		idle_source();
		drain_results();
		write_reg(REG_CAMERA_HEIGHT, 16'd0);
		send_pixel(9'd100, 9'd300, 1'b0, '0);
		idle_source();
		drain_results();
		write_reg(3'd7, 16'hFFFF);

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_FORWARD_OFFSET, 16'h0400);
					write_reg(REG_LATERAL_OFFSET, 16'h03FF);
					write_reg(REG_CAMERA_HEIGHT, 16'hFFFF);
					write_reg(REG_VERT_SCALE, 16'hFFFF);
					write_reg(REG_HORZ_SCALE, 16'hFFFF);
					write_reg(REG_VERT_BASE_ANGLE, 16'h8000);
					write_reg(REG_HORZ_BASE_ANGLE, 16'h7FFF);
				end
				1: begin
					write_reg(REG_FORWARD_OFFSET, 16'h03FF);
					write_reg(REG_LATERAL_OFFSET, 16'h0400);
					write_reg(REG_VERT_BASE_ANGLE, 16'h7FFF);
					write_reg(REG_HORZ_BASE_ANGLE, 16'h8000);
					write_reg(REG_CAMERA_HEIGHT, 16'd1);
				end
				default: begin
					write_reg(REG_FORWARD_OFFSET, 16'($urandom_range(0, 400) - 200));
					write_reg(REG_LATERAL_OFFSET, 16'($urandom_range(0, 200) - 100));
					write_reg(REG_CAMERA_HEIGHT, 16'($urandom_range(0, 4000)));
					write_reg(REG_VERT_BASE_ANGLE, 16'($urandom_range(0, 8000) - 6000));
					write_reg(REG_HORZ_BASE_ANGLE, 16'($urandom_range(0, 4000) - 8000));
					write_reg(REG_VERT_SCALE, 16'($urandom_range(2000, 20000)));
					write_reg(REG_HORZ_SCALE, 16'($urandom_range(5000, 40000)));
				end
			endcase
			if (ph == 3)
				hold_go = 1'b1;
			if (ph == 6) begin
				src_gaps = 1'b0;
				sink_quiet = 1'b1;
			end
			random_phase(ph < 2 ? 150 : 330);
			drain_results();
		end

		if (fail_cnt == 0)
			$display("inverse_perspective_remap_address_unit regression: pass");
		else
			$display("inverse_perspective_remap_address_unit regression: fail");
		$finish;
	end
endmodule
